>>> hw/rtl/pfc_pkg.sv
// Shared constants, types and the CRC step function for the packet framer.
package pfc_pkg;

  localparam int unsigned PAYLOAD_BYTES = 13;
  localparam int unsigned CRC_STEPS     = 15;

  localparam int unsigned POS_W = $clog2(PAYLOAD_BYTES + 1);

  // CRC is split over two passes of the shared step unit
  localparam int unsigned CRC_STEPS_A = (CRC_STEPS > 8) ? 8 : CRC_STEPS;
  localparam int unsigned CRC_STEPS_B = CRC_STEPS - CRC_STEPS_A;

  localparam logic [7:0] PREAMBLE_BYTE = 8'hAA;
  localparam logic [7:0] SYNC_HI       = 8'h2D;
  localparam logic [7:0] SYNC_LO       = 8'hD4;
  localparam logic [7:0] CHAR_ZERO     = 8'd48;
  localparam logic [7:0] CHAR_X        = 8'h58;
  localparam logic [7:0] DEST_MAX      = 8'd9;

  localparam logic [7:0] SOURCE_ID_RST = 8'd49;
  localparam logic [7:0] CRC_MASK_RST  = 8'h99;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ID = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_MASK  = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // preamble/sync beat counter, 0..4
  localparam int unsigned HDR_BEATS = 5;
  localparam int unsigned CNT_W     = $clog2(HDR_BEATS);
  localparam int unsigned POST_BEATS = 3;

  // one classified payload item
  typedef struct packed {
    logic [7:0] sent;
    logic [7:0] dchar;
    logic       first;
    logic       last;
  } pfc_entry_t;

  typedef enum logic [6:0] {
    ST_START = 7'b0000001,
    ST_PRE   = 7'b0000010,
    ST_PAY   = 7'b0000100,
    ST_SRC   = 7'b0001000,
    ST_DST   = 7'b0010000,
    ST_CRC   = 7'b0100000,
    ST_POST  = 7'b1000000
  } pfc_state_e;

  // up to eight right-shift CRC steps; data bits run out to zero
  function automatic logic [7:0] crc_run(logic [7:0] crc, logic [7:0] data,
                                         logic [7:0] mask, int unsigned steps);
    logic [7:0] c;
    logic [7:0] d;
    logic       fb;
    c = crc;
    d = data;
    for (int k = 0; k < 8; k++) begin
      if (k < steps) begin
        fb = c[0] ^ d[0];
        c  = {1'b0, c[7:1]} ^ (fb ? mask : 8'h00);
        d  = {1'b0, d[7:1]};
      end
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/pfc_front.sv
// Front end: accepts payload beats, tracks frame position and classifies items.
module pfc_front import pfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [7:0]  payload_byte_i,
  input  logic [7:0]  dest_node_i,
  output logic        in_ready_o,
  input  logic        q_ready_i,
  output logic        push_o,
  output pfc_entry_t  entry_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic             ended_q, ended_d;
  logic             first, last, zero_out;

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i & q_ready_i;

  assign first    = (pos_q == '0);
  assign last     = (pos_q == POS_W'(PAYLOAD_BYTES - 1));
  assign zero_out = (ended_q & ~first) | (payload_byte_i == 8'h00);

  always_comb begin
    entry_o.sent  = zero_out ? 8'h00 : payload_byte_i;
    entry_o.dchar = (dest_node_i <= DEST_MAX) ? (dest_node_i + CHAR_ZERO) : CHAR_X;
    entry_o.first = first;
    entry_o.last  = last;
  end

  always_comb begin
    pos_d   = pos_q;
    ended_d = ended_q;
    if (push_o) begin
      pos_d   = last ? '0 : pos_q + POS_W'(1);
      ended_d = ~last & zero_out;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      ended_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      ended_q <= ended_d;
    end
  end

endmodule

>>> hw/rtl/pfc_queue.sv
// Short FIFO of classified items between front and back.
module pfc_queue import pfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  pfc_entry_t push_data_i,
  output logic       ready_o,
  input  logic       pop_i,
  output logic       head_valid_o,
  output pfc_entry_t head_o
);

  pfc_entry_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign ready_o      = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & head_valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + QPTR_W'(1) : wr_q;
    rd_d  = do_pop  ? rd_q + QPTR_W'(1) : rd_q;
    cnt_d = cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> hw/rtl/pfc_back.sv
// Back end: beat sequencer, two-pass CRC unit and output register.
module pfc_back import pfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  pfc_entry_t head_i,
  output logic       pop_o,
  input  logic [7:0] source_id_i,
  input  logic [7:0] crc_mask_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       out_fend_o
);

  pfc_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       crc_q, crc_d;
  logic             busy_q, busy_d;
  logic             valid_q, valid_d;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;
  logic             fend_q, fend_d;

  logic       emit;
  logic       crc_start;
  logic       crc_clear;
  logic [7:0] crc_data;
  logic       do_pay;

  // CRC only idles between absorbed bytes, so every beat waits for it
  assign emit   = (~valid_q | out_ready_i) & head_valid_i & ~busy_q;
  assign do_pay = ((state_q == ST_START) & ~head_i.first) | (state_q == ST_PAY);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    valid_d   = valid_q & ~out_ready_i;
    byte_d    = byte_q;
    last_d    = last_q;
    fend_d    = fend_q;
    pop_o     = 1'b0;
    crc_start = 1'b0;
    crc_clear = 1'b0;
    crc_data  = head_i.sent;
    if (emit) begin
      valid_d = 1'b1;
      last_d  = 1'b0;
      fend_d  = 1'b0;
      if (do_pay) begin
        byte_d    = head_i.sent;
        crc_start = 1'b1;
        if (head_i.last) begin
          state_d = ST_SRC;
        end else begin
          last_d  = 1'b1;
          pop_o   = 1'b1;
          state_d = ST_START;
        end
      end else begin
        unique case (state_q)
          ST_START: begin
            byte_d    = PREAMBLE_BYTE;
            crc_clear = 1'b1;
            cnt_d     = CNT_W'(1);
            state_d   = ST_PRE;
          end
          ST_PRE: begin
            if (cnt_q == CNT_W'(HDR_BEATS - 2)) begin
              byte_d = SYNC_HI;
            end else if (cnt_q == CNT_W'(HDR_BEATS - 1)) begin
              byte_d = SYNC_LO;
            end else begin
              byte_d = PREAMBLE_BYTE;
            end
            cnt_d = cnt_q + CNT_W'(1);
            if (cnt_q == CNT_W'(HDR_BEATS - 1)) begin
              state_d = ST_PAY;
            end
          end
          ST_SRC: begin
            byte_d    = source_id_i;
            crc_data  = source_id_i;
            crc_start = 1'b1;
            state_d   = ST_DST;
          end
          ST_DST: begin
            byte_d    = head_i.dchar;
            crc_data  = head_i.dchar;
            crc_start = 1'b1;
            state_d   = ST_CRC;
          end
          ST_CRC: begin
            byte_d  = crc_q;
            cnt_d   = '0;
            state_d = ST_POST;
          end
          ST_POST: begin
            byte_d = PREAMBLE_BYTE;
            cnt_d  = cnt_q + CNT_W'(1);
            if (cnt_q == CNT_W'(POST_BEATS - 1)) begin
              last_d  = 1'b1;
              fend_d  = 1'b1;
              pop_o   = 1'b1;
              state_d = ST_START;
            end
          end
          default: begin
            state_d = ST_START;
          end
        endcase
      end
    end
  end

  // first pass takes the data bits, second pass runs on with zero data
  always_comb begin
    crc_d  = crc_q;
    busy_d = 1'b0;
    if (crc_clear) begin
      crc_d = 8'h00;
    end else if (crc_start) begin
      crc_d  = crc_run(crc_q, crc_data, crc_mask_i, CRC_STEPS_A);
      busy_d = (CRC_STEPS_B != 0);
    end else if (busy_q) begin
      crc_d = crc_run(crc_q, 8'h00, crc_mask_i, CRC_STEPS_B);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_START;
      cnt_q   <= '0;
      crc_q   <= '0;
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      busy_q  <= busy_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    fend_q <= fend_d;
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;
  assign out_fend_o  = fend_q;

endmodule

>>> hw/rtl/packet_framer_crc_tx_core.sv
// The first output beat of an item is registered from the queue head that the accepting edge
// wrote, with the queue empty and the back end idle.
// Per item: a middle payload item is a payload beat and two CRC passes of 8 and 7 steps;
// the first item of a frame is 5 header beats, its payload beat and the second CRC pass, the
// final one has three CRC updates that each take two passes; the 4-entry queue absorbs
// input bursts.
// Reset: source_id = 49, crc_mask = 0x99, queue empty, frame position and CRC at zero.
module packet_framer_crc_tx_core import pfc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,  // [7:0] payload_byte, [15:8] dest_node
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,  // [7:0] tx_byte
  output logic                 m_axis_tlast,  // last_of_run
  output logic                 m_axis_tuser,  // [0] frame_end
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i
);

  logic [7:0] source_id_q, source_id_d;
  logic [7:0] crc_mask_q, crc_mask_d;

  logic       q_ready, q_push, q_pop, q_head_valid;
  pfc_entry_t q_in, q_head;

  always_comb begin
    source_id_d = source_id_q;
    crc_mask_d  = crc_mask_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SOURCE_ID: source_id_d = cfg_wdata_i;
        CFG_CRC_MASK:  crc_mask_d  = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_id_q <= SOURCE_ID_RST;
      crc_mask_q  <= CRC_MASK_RST;
    end else begin
      source_id_q <= source_id_d;
      crc_mask_q  <= crc_mask_d;
    end
  end

  pfc_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i     (s_axis_tvalid),
    .payload_byte_i (s_axis_tdata[7:0]),
    .dest_node_i    (s_axis_tdata[15:8]),
    .in_ready_o     (s_axis_tready),
    .q_ready_i      (q_ready),
    .push_o         (q_push),
    .entry_o        (q_in)
  );

  pfc_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i       (q_push),
    .push_data_i  (q_in),
    .ready_o      (q_ready),
    .pop_i        (q_pop),
    .head_valid_o (q_head_valid),
    .head_o       (q_head)
  );

  pfc_back u_back (
    .clk_i,
    .rst_ni,
    .head_valid_i (q_head_valid),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .source_id_i  (source_id_q),
    .crc_mask_i   (crc_mask_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast),
    .out_fend_o   (m_axis_tuser)
  );

  // frame end always closes the run of the final item
  a_fend_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("frame end beat without tlast");

  // back end only retires items that are present
  a_pop_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_head_valid)
    else $error("queue pop while empty");

  // input stalls only when the queue holds work
  a_stall_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> q_head_valid)
    else $error("input stalled with empty queue");

  // each retired item ends a run on the next beat
  a_pop_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> m_axis_tvalid && m_axis_tlast)
    else $error("item retired without run end beat");

endmodule

>>> sim/tb_packet_framer_crc_tx_core.sv
// Self-checking testbench for the packet framer: payload beats in, framed radio bytes out.
module tb_packet_framer_crc_tx_core;
  import pfc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES   = 160;
  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_GUARD   = 4000;
  localparam int PHASES        = 7;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
    logic       fend;
  } tx_beat_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata  = '0;  // [7:0] payload_byte, [15:8] dest_node
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;        // [7:0] tx_byte
  logic                 m_axis_tlast;
  logic                 m_axis_tuser;        // [0] frame_end
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = CFG_SOURCE_ID;
  logic [7:0]           cfg_wdata_i   = '0;

  packet_framer_crc_tx_core dut (.*);

  // framer state as the predictor sees it
  logic [7:0] node_id  = SOURCE_ID_RST;
  logic [7:0] crc_poly = CRC_MASK_RST;
  logic [7:0] frame_crc = '0;
  int         frame_pos = 0;
  logic       str_done  = 1'b0;

  tx_beat_t    tx_bytes_due[$];
  logic [15:0] payload_backlog[$];

  logic idle_on  = 1'b0;
  logic hold_req = 1'b0;
  int   src_gap  = 0;
  int   rcv_gap  = 0;
  int   hold_cnt = 0;
  int   q_pos    = 0;

  int items_queued = 0;
  int items_taken  = 0;
  int beats_seen   = 0;
  int frames_done  = 0;
  int cfg_writes   = 0;
  int errors       = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(string msg);
    errors++;
    if (errors <= 40) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // right-shifting CRC; steps past the eighth shift in zero data bits
  function automatic logic [7:0] crc8_bits(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    c = crc;
    d = data;
    for (int k = 0; k < CRC_STEPS; k++) begin
      if (c[0] ^ d[0]) c = (c >> 1) ^ crc_poly;
      else c = c >> 1;
      d = d >> 1;
    end
    return c;
  endfunction

  function automatic void due(logic [7:0] v, logic fe);
    tx_bytes_due.push_back('{tx_byte: v, last: 1'b0, fend: fe});
  endfunction

  // expected radio bytes for one accepted payload beat
  task automatic emit_frame_bytes(logic [7:0] pb, logic [7:0] dn);
    logic [7:0] sent;
    logic [7:0] dchar;
    tx_beat_t   tail;
    if (frame_pos == 0) begin
      str_done  = 1'b0;
      frame_crc = '0;
      due(PREAMBLE_BYTE, 1'b0);
      due(PREAMBLE_BYTE, 1'b0);
      due(PREAMBLE_BYTE, 1'b0);
      due(SYNC_HI, 1'b0);
      due(SYNC_LO, 1'b0);
    end
    if (str_done || pb == 8'h00) begin
      str_done = 1'b1;
      sent = 8'h00;
    end else begin
      sent = pb;
    end
    due(sent, 1'b0);
    frame_crc = crc8_bits(frame_crc, sent);
    if (frame_pos + 1 >= PAYLOAD_BYTES) begin
      dchar = (dn <= DEST_MAX) ? dn + CHAR_ZERO : CHAR_X;
      due(node_id, 1'b0);
      frame_crc = crc8_bits(frame_crc, node_id);
      due(dchar, 1'b0);
      frame_crc = crc8_bits(frame_crc, dchar);
      due(frame_crc, 1'b0);
      due(PREAMBLE_BYTE, 1'b0);
      due(PREAMBLE_BYTE, 1'b0);
      due(PREAMBLE_BYTE, 1'b1);
      frame_pos = 0;
      frame_crc = '0;
      str_done  = 1'b0;
      frames_done++;
    end else begin
      frame_pos++;
    end
    tail = tx_bytes_due.pop_back();
    tail.last = 1'b1;
    tx_bytes_due.push_back(tail);
  endtask

  // sender: one beat per handshake, random gaps after a beat when enabled
  always @(posedge clk_i or negedge rst_ni) begin : feed
    logic        nv;
    logic [15:0] nd;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      src_gap = 0;
    end else begin
      nv = s_axis_tvalid;
      nd = s_axis_tdata;
      if (s_axis_tvalid && s_axis_tready) begin
        emit_frame_bytes(s_axis_tdata[7:0], s_axis_tdata[15:8]);
        items_taken++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (payload_backlog.size() > 0) begin
          nd = payload_backlog.pop_front();
          nv = 1'b1;
          if (idle_on && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 5);
        end
      end
      s_axis_tvalid <= nv;
      s_axis_tdata  <= nd;
    end
  end

  // receiver: one long hold-off on request, otherwise short random stall bursts when enabled
  always @(posedge clk_i or negedge rst_ni) begin : drain
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
      hold_cnt++;
      m_axis_tready <= 1'b0;
    end else if (rcv_gap > 0) begin
      rcv_gap--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      rcv_gap = $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check
    tx_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      beats_seen++;
      if (tx_bytes_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat tx_byte=%02h", m_axis_tdata));
      end else begin
        want = tx_bytes_due.pop_front();
        if (m_axis_tdata !== want.tx_byte)
          flag_mismatch($sformatf("beat %0d tx_byte %02h, want %02h",
                                  beats_seen, m_axis_tdata, want.tx_byte));
        if (m_axis_tlast !== want.last)
          flag_mismatch($sformatf("beat %0d last_of_run %b, want %b",
                                  beats_seen, m_axis_tlast, want.last));
        if (m_axis_tuser !== want.fend)
          flag_mismatch($sformatf("beat %0d frame_end %b, want %b",
                                  beats_seen, m_axis_tuser, want.fend));
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_SOURCE_ID) node_id = val;
    else crc_poly = val;
    cfg_writes++;
  endtask

  task automatic queue_item(logic [7:0] pb, logic [7:0] dn);
    payload_backlog.push_back({dn, pb});
    items_queued++;
    q_pos = (q_pos + 1) % PAYLOAD_BYTES;
  endtask

  task automatic queue_random_items(int count);
    logic [7:0] pb;
    logic [7:0] dn;
    for (int i = 0; i < count; i++) begin
      pb = ($urandom_range(0, 24) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      if (q_pos == PAYLOAD_BYTES - 1) begin
        case ($urandom_range(0, 5))
          0, 1, 2: dn = 8'($urandom_range(0, 9));
          3:       dn = 8'($urandom_range(10, 11));
          default: dn = 8'($urandom_range(0, 255));
        endcase
      end else begin
        dn = 8'($urandom_range(0, 255));
      end
      queue_item(pb, dn);
    end
  endtask

  // all beats accepted, all expected bytes seen or the drain guard spent, then a quiet settle
  task automatic wait_drained();
    int guard;
    guard = 0;
    while (items_taken != items_queued) @(posedge clk_i);
    while (tx_bytes_due.size() > 0 && guard < DRAIN_GUARD) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [7:0] frame_a[PAYLOAD_BYTES];
    logic [7:0] frame_b[PAYLOAD_BYTES];
    frame_a = '{8'hFF, 8'h01, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'hFE,
                8'h02, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04};
    // zero in the middle: everything after it goes out as zero
    frame_b = '{8'h12, 8'h34, 8'h56, 8'h78, 8'h00, 8'hFF, 8'h9A,
                8'h01, 8'hBC, 8'hDE, 8'hF0, 8'h11, 8'h80};
    repeat (11) @(posedge clk_i);
    rst_ni  <= 1'b1;
    idle_on <= 1'b1;

    // reset register values; digit destination 9, then out-of-range 255
    for (int i = 0; i < PAYLOAD_BYTES; i++)
      queue_item(frame_a[i], (i == PAYLOAD_BYTES - 1) ? 8'd9 : 8'd0);
    for (int i = 0; i < PAYLOAD_BYTES; i++)
      queue_item(frame_b[i], (i == PAYLOAD_BYTES - 1) ? 8'd255 : 8'd10);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          write_reg(CFG_SOURCE_ID, 8'h00);
          write_reg(CFG_CRC_MASK, 8'h00);
        end
        1: begin
          write_reg(CFG_SOURCE_ID, 8'hFF);
          write_reg(CFG_CRC_MASK, 8'hFF);
        end
        2: begin
          write_reg(CFG_SOURCE_ID, 8'($urandom_range(0, 255)));
          write_reg(CFG_CRC_MASK, 8'h8C);
          // sender keeps offering while the receiver holds off
          idle_on  <= 1'b0;
          hold_req <= 1'b1;
        end
        3: begin
          write_reg(CFG_SOURCE_ID, SOURCE_ID_RST);
          write_reg(CFG_CRC_MASK, CRC_MASK_RST);
          idle_on <= 1'b1;
        end
        PHASES - 1: begin
          write_reg(CFG_SOURCE_ID, 8'($urandom_range(0, 255)));
          write_reg(CFG_CRC_MASK, 8'($urandom_range(0, 255)));
          idle_on <= 1'b0;
        end
        default: begin
          write_reg(CFG_SOURCE_ID, 8'($urandom_range(0, 255)));
          write_reg(CFG_CRC_MASK, 8'($urandom_range(0, 255)));
        end
      endcase
      queue_random_items($urandom_range(52, 68));
      wait_drained();
    end

    if (tx_bytes_due.size() != 0)
      flag_mismatch($sformatf("%0d expected beats never arrived", tx_bytes_due.size()));
    $display("Run covered %0d payload beats in %0d complete frames, %0d output beats checked.",
             items_taken, frames_done, beats_seen);
    $display("Register writes: %0d (zero, all-ones, reset and random values); mismatches: %0d.",
             cfg_writes, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("Timeout: %0d of %0d beats accepted, %0d bytes outstanding",
             items_taken, items_queued, tx_bytes_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/pfc_pkg.sv
hw/rtl/pfc_front.sv
hw/rtl/pfc_queue.sv
hw/rtl/pfc_back.sv
hw/rtl/packet_framer_crc_tx_core.sv
sim/tb_packet_framer_crc_tx_core.sv
